>>> src/sine_wave_level_generator_top_assert.svh
// Assertion macros for the sine level generator.
`ifndef SINE_WAVE_LEVEL_GENERATOR_TOP_ASSERT_SVH
`define SINE_WAVE_LEVEL_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SWLG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWLG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/swlg_pkg.sv
// Shared types, constants and functions of the sine level generator.
package swlg_pkg;

   localparam int SINE_TABLE_BITS_DEF = 10;

   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 24;
   localparam int GAIN_W   = 19;
   localparam int LEVEL_W  = 17;
   localparam int CSR_W    = 32;
   localparam int CSR_A_W  = 3;
   localparam int SUM_W    = TIME_W + 1;  // t + phase
   localparam int Q30_W    = 31;          // Q30 values up to 1.0 and the coefficients
   localparam int SINE_W   = 18;          // signed Q16 sine, -65536..65536

   // register indexes
   localparam logic [CSR_A_W-1:0] CSR_PERIOD    = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_MAGNITUDE = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_PHASE     = 3'd2;
   localparam logic [CSR_A_W-1:0] CSR_OFFSET    = 3'd3;
   localparam logic [CSR_A_W-1:0] CSR_MODE      = 3'd4;
   localparam logic [CSR_A_W-1:0] CSR_LENGTH    = 3'd5;

   // register reset values
   localparam logic [PERIOD_W-1:0]      PERIOD_RST    = 24'd1000;
   localparam logic signed [GAIN_W-1:0] MAGNITUDE_RST = 19'sd32768;
   localparam logic [PERIOD_W-1:0]      PHASE_RST     = 24'd0;
   localparam logic signed [GAIN_W-1:0] OFFSET_RST    = 19'sd32768;
   localparam logic                     MODE_ABS      = 1'b0;
   localparam logic                     MODE_REL      = 1'b1;
   localparam logic [TIME_W-1:0]        LENGTH_RST    = 32'hFFFF_FFFF;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 17'd65536;

   // odd polynomial for sin(pi/2 * x), Q30
   localparam logic [Q30_W-1:0] C1 = 31'd1686629713;
   localparam logic [Q30_W-1:0] C3 = 31'd693598669;
   localparam logic [Q30_W-1:0] C5 = 31'd85569306;
   localparam logic [Q30_W-1:0] C7 = 31'd5026995;
   localparam logic [Q30_W-1:0] C9 = 31'd172272;
   localparam int HORNER_STEPS = 4;

   // per-word sideband carried alongside the datapath
   typedef struct packed {
      logic               ok;
      logic [LEVEL_W-1:0] cur;
   } swlg_side_type;

   // coefficient that Horner step j subtracts from
   function automatic logic [Q30_W-1:0] horner_coef(input int j);
      logic [Q30_W-1:0] c;
      case (j)
         0:       c = C7;
         1:       c = C5;
         2:       c = C3;
         default: c = C1;
      endcase
      return c;
   endfunction

endpackage

>>> src/sine_wave_level_generator_top.sv
// Top level of the sine level generator: registers, front stage, scaling and output.
//
// Use: send one query word per req_ handshake (time in ms, current level, kind flag);
// one result word comes back on rsp_ for every query, in order.
// req_tdata  : time_ms[31:0], current_level[48:32], zero fill to 56 bits.
// req_tuser  : kind_supported.
// rsp_tdata  : level[16:0], zero fill to 24 bits.
// rsp_tuser  : has_value (level is forced to 0 when clear).
// csr_       : plain write port; index 0 period, 1 magnitude, 2 phase, 3 offset,
//              4 mode, 5 length. Write only while no query is in flight.
// Pipeline   : from accept to rsp_tvalid, 1 clamp/add stage, 33 modulo stages,
//              SINE_TABLE_BITS + 2 angle stages, 8 sine stages, 1 gain multiply and
//              1 output register.
// Throughput : one word per cycle unless the pipe stalls; the modulo and angle dividers
//              retire one bit per stage and every multiplier has its own stage.
// Stall      : while the output word is held the gain stage can still fill; once it is
//              full the whole pipe holds and req_tready drops. Nothing is lost or repeated.
// Reset      : synchronous; empties the pipe and loads register defaults
//              (period 1000, magnitude 0.5, phase 0, offset 0.5, absolute, no length limit).
module sine_wave_level_generator_top import swlg_pkg::*; #(
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // query channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [55:0]        req_tdata,   // time_ms[31:0], current_level[48:32]
   input  logic               req_tuser,   // kind_supported
   // result channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,   // level[16:0]
   output logic               rsp_tuser,   // has_value
   // register writes
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata
);

   localparam int ANG_W = SINE_TABLE_BITS + 2;

   // ---- configuration registers ----
   logic [PERIOD_W-1:0]      period_ff;
   logic signed [GAIN_W-1:0] mag_ff;
   logic [PERIOD_W-1:0]      phase_ff;
   logic signed [GAIN_W-1:0] off_ff;
   logic                     mode_ff;
   logic [TIME_W-1:0]        length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RST;
         mag_ff    <= MAGNITUDE_RST;
         phase_ff  <= PHASE_RST;
         off_ff    <= OFFSET_RST;
         mode_ff   <= MODE_ABS;
         length_ff <= LENGTH_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PERIOD:    period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_MAGNITUDE: mag_ff    <= $signed(csr_wdata[GAIN_W-1:0]);
            CSR_PHASE:     phase_ff  <= csr_wdata[PERIOD_W-1:0];
            CSR_OFFSET:    off_ff    <= $signed(csr_wdata[GAIN_W-1:0]);
            CSR_MODE:      mode_ff   <= csr_wdata[0];
            CSR_LENGTH:    length_ff <= csr_wdata[TIME_W-1:0];
            default:       ;
         endcase
      end
   end

   // zero period acts as one
   logic [PERIOD_W-1:0] per_eff;
   assign per_eff = (period_ff == '0) ? PERIOD_W'(1) : period_ff;

   // ---- pipeline advance ----
   logic rsp_valid_ff;
   logic mul_valid_ff;
   logic out_take;
   logic en;

   assign out_take   = !rsp_valid_ff || rsp_tready;
   assign en         = out_take || !mul_valid_ff;  // only a full tail stalls the pipe
   assign req_tready = en;

   // ---- stage 0: clamp to timeline and add phase ----
   logic              v0_ff;
   logic [SUM_W-1:0]  t0_ff, t0_in;
   swlg_side_type     sd0_ff, sd0_in;
   logic [TIME_W-1:0] t_clamp;

   always_comb begin
      t_clamp    = (req_tdata[31:0] > length_ff) ? length_ff : req_tdata[31:0];
      t0_in      = {1'b0, t_clamp} + SUM_W'(phase_ff);
      sd0_in.ok  = req_tuser;
      sd0_in.cur = req_tdata[48:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t0_ff  <= t0_in;
         sd0_ff <= sd0_in;
      end
   end

   // ---- (t + phase) mod period ----
   logic                mod_valid;
   logic [SUM_W-1:0]    mod_quot;
   logic [PERIOD_W-1:0] mod_rem;
   swlg_side_type       mod_side;

   swlg_div #(
      .DEN_W (PERIOD_W),
      .NB    (SUM_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .den       (per_eff),
      .src_valid (v0_ff),
      .src_rem   ('0),
      .src_num   (t0_ff),
      .src_side  (sd0_ff),
      .dst_valid (mod_valid),
      .dst_quot  (mod_quot),
      .dst_rem   (mod_rem),
      .dst_side  (mod_side)
   );

   // ---- angle = remainder * 4 * 2^bits / period ----
   logic                ang_valid;
   logic [ANG_W-1:0]    ang_quot;
   logic [PERIOD_W-1:0] ang_rem;
   swlg_side_type       ang_side;

   swlg_div #(
      .DEN_W (PERIOD_W),
      .NB    (ANG_W)
   ) u_angle (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .den       (per_eff),
      .src_valid (mod_valid),
      .src_rem   (mod_rem),
      .src_num   ('0),
      .src_side  (mod_side),
      .dst_valid (ang_valid),
      .dst_quot  (ang_quot),
      .dst_rem   (ang_rem),
      .dst_side  (ang_side)
   );

   // ---- sine ----
   logic                     sin_valid;
   logic signed [SINE_W-1:0] sin_val;
   swlg_side_type            sin_side;

   swlg_sine #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_sine (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .src_valid (ang_valid),
      .src_angle (ang_quot),
      .src_side  (ang_side),
      .dst_valid (sin_valid),
      .dst_sine  (sin_val),
      .dst_side  (sin_side)
   );

   // ---- gain multiply ----
   localparam int PROD_W = GAIN_W + SINE_W;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   swlg_side_type            sdm_ff;

   assign prod_in = PROD_W'(mag_ff) * PROD_W'(sin_val);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= sin_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         sdm_ff  <= sin_side;
      end
   end

   // ---- round, add offset (and current level), saturate, output register ----
   localparam int WAVE_W = PROD_W - 16;
   localparam int ACC_W  = WAVE_W + 2;

   logic signed [PROD_W-1:0]  prod_rnd;
   logic signed [WAVE_W-1:0]  wave;
   logic signed [ACC_W-1:0]   cur_ext;
   logic signed [ACC_W-1:0]   total;
   logic [LEVEL_W-1:0]        level_in, level_ff;
   logic                      has_in, has_ff;

   always_comb begin
      prod_rnd = prod_ff + PROD_W'(32768);
      wave     = $signed(prod_rnd[PROD_W-1:16]);         // floor division by 65536
      cur_ext  = $signed({{(ACC_W-LEVEL_W){1'b0}}, sdm_ff.cur});
      total    = ACC_W'(wave) + ACC_W'(off_ff) + ((mode_ff == MODE_REL) ? cur_ext : '0);
      if (!sdm_ff.ok) begin
         level_in = '0;
      end else if (total < 0) begin
         level_in = '0;
      end else if (total > ACC_W'(LEVEL_FULL)) begin
         level_in = LEVEL_FULL;
      end else begin
         level_in = total[LEVEL_W-1:0];
      end
      has_in = sdm_ff.ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         level_ff <= level_in;
         has_ff   <= has_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(24-LEVEL_W){1'b0}}, level_ff};
   assign rsp_tuser  = has_ff;

`include "sine_wave_level_generator_top_assert.svh"

   // a full tail behind a held word must block new queries
   `SWLG_ASSERT_NOW(a_stall_blocks_req, clock, reset, mul_valid_ff && rsp_valid_ff && !rsp_tready, !req_tready, "query accepted while pipe tail is blocked")
   // the tail word holds while the output register cannot take it
   `SWLG_ASSERT_NEXT(a_tail_holds, clock, reset, mul_valid_ff && !out_take, mul_valid_ff && $stable(prod_ff), "tail word lost or changed during stall")
   // a tail word taken by the output register shows up as a result
   `SWLG_ASSERT_NEXT(a_tail_to_out, clock, reset, mul_valid_ff && out_take, rsp_valid_ff, "tail word dropped on its way out")
   // a result without value carries a zero level
   `SWLG_ASSERT_NOW(a_novalue_zero, clock, reset, rsp_valid_ff && !rsp_tuser, rsp_tdata == '0, "level not zero for unsupported kind")

endmodule

>>> src/swlg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module swlg_div import swlg_pkg::*; #(
   parameter int DEN_W = PERIOD_W,
   parameter int NB    = SUM_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [DEN_W-1:0] den,       // divisor, non-zero, steady while words are in flight
   input  logic             src_valid,
   input  logic [DEN_W-1:0] src_rem,   // starting remainder, below den
   input  logic [NB-1:0]    src_num,   // numerator bits shifted in, MSB first
   input  swlg_side_type    src_side,
   output logic             dst_valid,
   output logic [NB-1:0]    dst_quot,
   output logic [DEN_W-1:0] dst_rem,
   output swlg_side_type    dst_side
);

   logic             valid_w [0:NB];
   logic [DEN_W-1:0] rem_w   [0:NB];
   logic [NB-1:0]    num_w   [0:NB];
   logic [NB-1:0]    quot_w  [0:NB];
   swlg_side_type    side_w  [0:NB];

   assign valid_w[0] = src_valid;
   assign rem_w[0]   = src_rem;
   assign num_w[0]   = src_num;
   assign quot_w[0]  = '0;
   assign side_w[0]  = src_side;

   for (genvar g = 0; g < NB; g++) begin : g_stage
      logic             valid_ff;
      logic [DEN_W-1:0] rem_ff, rem_in;
      logic [NB-1:0]    num_ff, num_in;
      logic [NB-1:0]    quot_ff, quot_in;
      swlg_side_type    side_ff;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             fits;

      always_comb begin
         trial   = {rem_w[g], num_w[g][NB-1]};
         diff    = trial - {1'b0, den};
         fits    = (trial >= {1'b0, den});
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         num_in  = {num_w[g][NB-2:0], 1'b0};
         quot_in = {quot_w[g][NB-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= valid_w[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            num_ff  <= num_in;
            quot_ff <= quot_in;
            side_ff <= side_w[g];
         end
      end

      assign valid_w[g+1] = valid_ff;
      assign rem_w[g+1]   = rem_ff;
      assign num_w[g+1]   = num_ff;
      assign quot_w[g+1]  = quot_ff;
      assign side_w[g+1]  = side_ff;
   end

   assign dst_valid = valid_w[NB];
   assign dst_quot  = quot_w[NB];
   assign dst_rem   = rem_w[NB];
   assign dst_side  = side_w[NB];

endmodule

>>> src/swlg_sine.sv
// Pipelined sine of a quantised angle: quadrant fold plus Horner polynomial.
module swlg_sine import swlg_pkg::*; #(
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     src_valid,
   input  logic [SINE_TABLE_BITS+1:0] src_angle,  // full turn = 4 * 2^SINE_TABLE_BITS
   input  swlg_side_type            src_side,
   output logic                     dst_valid,
   output logic signed [SINE_W-1:0] dst_sine,     // Q16
   output swlg_side_type            dst_side
);

   localparam int B = SINE_TABLE_BITS;
   localparam logic [B:0] QSIZE = (B+1)'(1) << B;

   // stage 1: fold to the first quadrant, scale to Q30
   logic             v1_ff;
   logic [Q30_W-1:0] x1_ff, x1_in;
   logic [1:0]       q1_ff;
   swlg_side_type    sd1_ff;
   logic [B:0]       kk;

   always_comb begin
      kk    = src_angle[B] ? (QSIZE - {1'b0, src_angle[B-1:0]}) : {1'b0, src_angle[B-1:0]};
      x1_in = {kk, {(Q30_W-B-1){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff  <= x1_in;
         q1_ff  <= src_angle[B+1:B];
         sd1_ff <= src_side;
      end
   end

   // stage 2: x squared
   logic             valid_w [0:HORNER_STEPS];
   logic [Q30_W-1:0] x_w     [0:HORNER_STEPS];
   logic [Q30_W-1:0] sq_w    [0:HORNER_STEPS];
   logic [Q30_W-1:0] acc_w   [0:HORNER_STEPS];
   logic [1:0]       q_w     [0:HORNER_STEPS];
   swlg_side_type    sd_w    [0:HORNER_STEPS];

   logic             v2_ff;
   logic [Q30_W-1:0] x2_ff, sq2_ff;
   logic [1:0]       q2_ff;
   swlg_side_type    sd2_ff;
   logic [2*Q30_W-1:0] sq_prod;

   assign sq_prod = (2*Q30_W)'(x1_ff) * (2*Q30_W)'(x1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x2_ff  <= x1_ff;
         sq2_ff <= sq_prod[60:30];
         q2_ff  <= q1_ff;
         sd2_ff <= sd1_ff;
      end
   end

   assign valid_w[0] = v2_ff;
   assign x_w[0]     = x2_ff;
   assign sq_w[0]    = sq2_ff;
   assign acc_w[0]   = C9;
   assign q_w[0]     = q2_ff;
   assign sd_w[0]    = sd2_ff;

   // Horner steps: acc = coef - (x^2 * acc) >> 30
   for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
      logic               valid_ff;
      logic [Q30_W-1:0]   x_ff, sq_ff, acc_ff, acc_in;
      logic [1:0]         q_ff;
      swlg_side_type      sd_ff;
      logic [2*Q30_W-1:0] prod;

      always_comb begin
         prod   = (2*Q30_W)'(sq_w[j]) * (2*Q30_W)'(acc_w[j]);
         acc_in = horner_coef(j) - prod[60:30];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= valid_w[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff   <= x_w[j];
            sq_ff  <= sq_w[j];
            acc_ff <= acc_in;
            q_ff   <= q_w[j];
            sd_ff  <= sd_w[j];
         end
      end

      assign valid_w[j+1] = valid_ff;
      assign x_w[j+1]     = x_ff;
      assign sq_w[j+1]    = sq_ff;
      assign acc_w[j+1]   = acc_ff;
      assign q_w[j+1]     = q_ff;
      assign sd_w[j+1]    = sd_ff;
   end

   // final multiply by x
   logic               vy_ff;
   logic [Q30_W-1:0]   y_ff;
   logic [1:0]         qy_ff;
   swlg_side_type      sdy_ff;
   logic [2*Q30_W-1:0] y_prod;

   assign y_prod = (2*Q30_W)'(x_w[HORNER_STEPS]) * (2*Q30_W)'(acc_w[HORNER_STEPS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vy_ff <= 1'b0;
      end else if (en) begin
         vy_ff <= valid_w[HORNER_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff   <= y_prod[60:30];
         qy_ff  <= q_w[HORNER_STEPS];
         sdy_ff <= sd_w[HORNER_STEPS];
      end
   end

   // round Q30 to Q16, limit to 1.0, sign from quadrant
   logic                     vs_ff;
   logic signed [SINE_W-1:0] s_ff, s_in;
   swlg_side_type            sds_ff;
   logic [Q30_W:0]           y_rnd;
   logic [SINE_W-1:0]        mag;

   always_comb begin
      y_rnd = {1'b0, y_ff} + (Q30_W+1)'(8192);
      mag   = y_rnd[Q30_W:14];
      if (mag > SINE_W'(LEVEL_FULL)) begin
         mag = SINE_W'(LEVEL_FULL);
      end
      s_in  = qy_ff[1] ? -$signed(mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= 1'b0;
      end else if (en) begin
         vs_ff <= vy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff   <= s_in;
         sds_ff <= sdy_ff;
      end
   end

   assign dst_valid = vs_ff;
   assign dst_sine  = s_ff;
   assign dst_side  = sds_ff;

endmodule
